/* hw/rtl/iddt_pkg.sv */
package iddt_pkg;

	localparam int MAX_PROCS_DEF     = 32;
	localparam int MAX_RESOURCES_DEF = 32;
	localparam int MAX_EDGES_DEF     = 256;

	localparam int RESULT_CAP = 32;
	localparam int ID_W       = 5;
	localparam int NUM_W      = 8;
	localparam int EDGE_W     = 2 * ID_W + 1;

	localparam logic DIR_REQUEST = 1'b0;
	localparam logic DIR_ASSIGN  = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0] process_id;
		logic [ID_W-1:0] resource_id;
		logic            edge_direction;
	} edge_item_t;

	typedef struct packed {
		logic             deadlocked;
		logic [ID_W-1:0]  stuck_process;
		logic [NUM_W-1:0] edge_number;
		logic             last_of_run;
		logic             edge_dropped;
	} result_item_t;

endpackage

/* hw/rtl/iddt_ram.sv */
module iddt_ram
	#(
		parameter int WIDTH = 8,
		parameter int DEPTH = 64
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic                     re,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/incremental_deadlock_detect_top.sv */
// Incremental deadlock detector over a wait-for graph.
// edge channel: one edge per item (process, resource, direction). Direction
// request makes the process point at the resource, assign makes the resource
// point at the process. The edge is stored, then the whole graph is peeled.
// result channel: one item per deadlocked process in ascending id order, the
// final one with last_of_run set; with no deadlock a single item with
// deadlocked low. At most 32 items per edge; full store or bad id sets
// edge_dropped and leaves the graph as it was.
// For each edge the block clears the degree memory, rebuilds out-degrees from
// the stored edges, seeds the zero stack with every node of out-degree zero,
// pops nodes and scans all stored edges for each, decrementing the out-degree
// of every source that points at it, and then reports the processes whose
// out-degree is still nonzero. Edges are taken one at a time: edge_stall stays
// high from acceptance until the last result has entered the output register.
// A result waits in the output register while result_stall is high; the scan
// waits behind it. Reset empties the edge store and returns to idle with no
// memory clearing pass.
module incremental_deadlock_detect_top
	import iddt_pkg::*;
	#(
		parameter int MAX_PROCS     = MAX_PROCS_DEF,
		parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
		parameter int MAX_EDGES     = MAX_EDGES_DEF
	)
	(
		input  logic         clk,
		input  logic         arst_n,
		input  logic         edge_valid,
		output logic         edge_stall,
		input  edge_item_t   edge_item,
		output logic         result_valid,
		input  logic         result_stall,
		output result_item_t result_item
	);

	localparam int N   = MAX_PROCS + MAX_RESOURCES;
	localparam int NW  = $clog2(N);
	localparam int CW  = $clog2(MAX_EDGES + 1);
	localparam int EAW = $clog2(MAX_EDGES);
	localparam int FW  = $clog2(RESULT_CAP + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_IRD   = 4'd2;
	localparam logic [3:0] S_IDEG  = 4'd3;
	localparam logic [3:0] S_IINC  = 4'd4;
	localparam logic [3:0] S_ZRD   = 4'd5;
	localparam logic [3:0] S_ZCHK  = 4'd6;
	localparam logic [3:0] S_POP   = 4'd7;
	localparam logic [3:0] S_PWAIT = 4'd8;
	localparam logic [3:0] S_PRD   = 4'd9;
	localparam logic [3:0] S_PDEC  = 4'd10;
	localparam logic [3:0] S_PUPD  = 4'd11;
	localparam logic [3:0] S_RRD   = 4'd12;
	localparam logic [3:0] S_RCHK  = 4'd13;
	localparam logic [3:0] S_FIN   = 4'd14;

	logic [3:0]       state_q;
	logic [NW-1:0]    idx_q;
	logic [CW-1:0]    e_q;
	logic [CW-1:0]    cnt_q;
	logic [NW:0]      top_q;
	logic [NW-1:0]    node_q;
	logic [NW-1:0]    src_q;
	logic [NUM_W-1:0] number_q;
	logic             dropped_q;
	logic             pend_v_q;
	logic [ID_W-1:0]  pend_id_q;
	logic [FW-1:0]    found_q;
	logic             out_v_q;
	result_item_t     out_q;

	logic              e_we, e_re;
	logic [EAW-1:0]    e_waddr, e_raddr;
	logic [EDGE_W-1:0] e_wdata, e_rdata;
	logic              d_we, d_re;
	logic [NW-1:0]     d_waddr, d_raddr;
	logic [CW-1:0]     d_wdata, d_rdata;
	logic              s_we, s_re;
	logic [NW-1:0]     s_waddr, s_raddr;
	logic [NW-1:0]     s_wdata, s_rdata;

	logic          drop;
	logic [NW-1:0] pnode, rnode, src, dst;
	logic          out_free;
	logic          out_load;

	iddt_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.re(e_re), .raddr(e_raddr), .rdata(e_rdata)
	);

	iddt_ram #(.WIDTH(CW), .DEPTH(N)) u_deg_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.re(d_re), .raddr(d_raddr), .rdata(d_rdata)
	);

	iddt_ram #(.WIDTH(NW), .DEPTH(N)) u_stack_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.re(s_re), .raddr(s_raddr), .rdata(s_rdata)
	);

	assign drop = (cnt_q == CW'(MAX_EDGES))
		|| (7'(edge_item.process_id) >= 7'(MAX_PROCS))
		|| (7'(edge_item.resource_id) >= 7'(MAX_RESOURCES));

	// stored edge word is {direction, resource, process}
	assign pnode = NW'(e_rdata[ID_W-1:0]);
	assign rnode = NW'(MAX_PROCS) + NW'(e_rdata[2*ID_W-1:ID_W]);
	assign src   = (e_rdata[EDGE_W-1] == DIR_ASSIGN) ? rnode : pnode;
	assign dst   = (e_rdata[EDGE_W-1] == DIR_ASSIGN) ? pnode : rnode;

	assign out_free     = !out_v_q || !result_stall;
	assign out_load     = ((state_q == S_RCHK) && (d_rdata != '0) && pend_v_q && out_free)
		|| ((state_q == S_FIN) && out_free);
	assign edge_stall   = (state_q != S_IDLE);
	assign result_valid = out_v_q;
	assign result_item  = out_q;

	always_comb begin
		e_we    = 1'b0;
		e_waddr = cnt_q[EAW-1:0];
		e_wdata = {edge_item.edge_direction, edge_item.resource_id, edge_item.process_id};
		e_re    = 1'b0;
		e_raddr = e_q[EAW-1:0];
		d_we    = 1'b0;
		d_waddr = src_q;
		d_wdata = '0;
		d_re    = 1'b0;
		d_raddr = src;
		s_we    = 1'b0;
		s_waddr = top_q[NW-1:0];
		s_wdata = idx_q;
		s_re    = 1'b0;
		s_raddr = NW'(top_q - 1'b1);
		case (state_q)
			S_IDLE: begin
				e_we = edge_valid && !drop;
			end
			S_CLR: begin
				d_we    = 1'b1;
				d_waddr = idx_q;
			end
			S_IRD, S_PRD: begin
				e_re = (e_q != cnt_q);
			end
			S_IDEG: begin
				d_re = 1'b1;
			end
			S_IINC: begin
				d_we    = 1'b1;
				d_wdata = d_rdata + 1'b1;
			end
			S_ZRD, S_RRD: begin
				d_re    = 1'b1;
				d_raddr = idx_q;
			end
			S_ZCHK: begin
				s_we = (d_rdata == '0);
			end
			S_POP: begin
				s_re = (top_q != '0);
			end
			S_PDEC: begin
				d_re = (dst == node_q);
			end
			S_PUPD: begin
				d_we    = (d_rdata != '0);
				d_wdata = d_rdata - 1'b1;
				s_we    = (d_rdata == CW'(1));
				s_wdata = src_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			top_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && !result_stall && !out_load) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (edge_valid) begin
						number_q  <= NUM_W'(cnt_q);
						dropped_q <= drop;
						if (!drop) begin
							cnt_q <= cnt_q + 1'b1;
						end
						idx_q   <= '0;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					if (idx_q == NW'(N - 1)) begin
						e_q     <= '0;
						state_q <= S_IRD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IRD: begin
					if (e_q == cnt_q) begin
						idx_q   <= '0;
						top_q   <= '0;
						state_q <= S_ZRD;
					end else begin
						state_q <= S_IDEG;
					end
				end
				S_IDEG: begin
					src_q   <= src;
					state_q <= S_IINC;
				end
				S_IINC: begin
					e_q     <= e_q + 1'b1;
					state_q <= S_IRD;
				end
				S_ZRD: begin
					state_q <= S_ZCHK;
				end
				S_ZCHK: begin
					if (d_rdata == '0) begin
						top_q <= top_q + 1'b1;
					end
					if (idx_q == NW'(N - 1)) begin
						state_q <= S_POP;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_ZRD;
					end
				end
				S_POP: begin
					if (top_q == '0) begin
						idx_q    <= '0;
						found_q  <= '0;
						pend_v_q <= 1'b0;
						state_q  <= S_RRD;
					end else begin
						top_q   <= top_q - 1'b1;
						state_q <= S_PWAIT;
					end
				end
				S_PWAIT: begin
					node_q  <= s_rdata;
					e_q     <= '0;
					state_q <= S_PRD;
				end
				S_PRD: begin
					state_q <= (e_q == cnt_q) ? S_POP : S_PDEC;
				end
				S_PDEC: begin
					e_q <= e_q + 1'b1;
					if (dst == node_q) begin
						src_q   <= src;
						state_q <= S_PUPD;
					end else begin
						state_q <= S_PRD;
					end
				end
				S_PUPD: begin
					if (d_rdata == CW'(1)) begin
						top_q <= top_q + 1'b1;
					end
					state_q <= S_PRD;
				end
				S_RRD: begin
					state_q <= S_RCHK;
				end
				S_RCHK: begin
					if (!(d_rdata != '0 && pend_v_q && !out_free)) begin
						if (d_rdata != '0) begin
							if (pend_v_q) begin
								out_v_q <= 1'b1;
								out_q   <= '{1'b1, pend_id_q, number_q, 1'b0, dropped_q};
							end
							pend_v_q  <= 1'b1;
							pend_id_q <= ID_W'(idx_q);
							found_q   <= found_q + 1'b1;
						end
						if ((d_rdata != '0 && found_q == FW'(RESULT_CAP - 1))
							|| idx_q == NW'(MAX_PROCS - 1)) begin
							state_q <= S_FIN;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RRD;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						out_q   <= '{pend_v_q, pend_v_q ? pend_id_q : '0, number_q, 1'b1,
							dropped_q};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import iddt_pkg::*;

	localparam int NODES      = MAX_PROCS_DEF + MAX_RESOURCES_DEF;
	localparam int IDLE_LIMIT = 400000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         edge_valid = 1'b0;
	logic         edge_stall;
	edge_item_t   edge_item = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_item_t result_item;

	result_item_t expected_results[$];
	logic [EDGE_W-1:0] graph_edges[MAX_EDGES_DEF];
	int stored_edges = 0;
	int out_degree[NODES];
	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	incremental_deadlock_detect_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.edge_valid(edge_valid),
		.edge_stall(edge_stall),
		.edge_item(edge_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic void edge_ends(input logic [EDGE_W-1:0] e, output int src, output int dst);
		if (e[EDGE_W-1] == DIR_ASSIGN) begin
			src = MAX_PROCS_DEF + int'(e[2*ID_W-1:ID_W]);
			dst = int'(e[ID_W-1:0]);
		end else begin
			src = int'(e[ID_W-1:0]);
			dst = MAX_PROCS_DEF + int'(e[2*ID_W-1:ID_W]);
		end
	endfunction

	function automatic void predict_deadlocks(input edge_item_t it);
		int work[NODES];
		int pending[NODES];
		int top;
		int node;
		int src;
		int dst;
		int k;
		int number;
		bit dropped;
		result_item_t res;
		number = stored_edges;
		dropped = stored_edges >= MAX_EDGES_DEF;
		if (!dropped) begin
			graph_edges[stored_edges] = {it.edge_direction, it.resource_id, it.process_id};
			edge_ends(graph_edges[stored_edges], src, dst);
			stored_edges++;
			out_degree[src]++;
		end
		top = 0;
		for (int n = 0; n < NODES; n++) begin
			work[n] = out_degree[n];
			if (work[n] == 0) begin
				pending[top] = n;
				top++;
			end
		end
		while (top > 0) begin
			top--;
			node = pending[top];
			for (int e = 0; e < stored_edges; e++) begin
				edge_ends(graph_edges[e], src, dst);
				if (dst == node && work[src] != 0) begin
					work[src]--;
					if (work[src] == 0) begin
						pending[top] = src;
						top++;
					end
				end
			end
		end
		k = 0;
		for (int n = 0; n < MAX_PROCS_DEF && k < RESULT_CAP; n++) begin
			if (work[n] != 0) begin
				res.deadlocked = 1'b1;
				res.stuck_process = n[ID_W-1:0];
				res.edge_number = number[NUM_W-1:0];
				res.last_of_run = 1'b0;
				res.edge_dropped = dropped;
				expected_results = {expected_results, res};
				k++;
			end
		end
		if (k == 0) begin
			res.deadlocked = 1'b0;
			res.stuck_process = '0;
			res.edge_number = number[NUM_W-1:0];
			res.last_of_run = 1'b1;
			res.edge_dropped = dropped;
			expected_results = {expected_results, res};
		end else begin
			expected_results[expected_results.size()-1].last_of_run = 1'b1;
		end
	endfunction

	task automatic send_edge(input int p, input int r, input int d);
		edge_item_t it;
		it.process_id = p[ID_W-1:0];
		it.resource_id = r[ID_W-1:0];
		it.edge_direction = d[0];
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			edge_valid <= 1'b0;
			@(negedge clk);
		end
		edge_item <= it;
		edge_valid <= 1'b1;
		do @(posedge clk); while (edge_stall);
		predict_deadlocks(it);
	endtask

	task automatic drain;
		@(negedge clk);
		edge_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_random_edge;
		int p;
		int r;
		if ($urandom_range(0, 3) == 0) begin
			p = $urandom_range(0, 31);
			r = $urandom_range(0, 31);
		end else begin
			p = $urandom_range(0, 7);
			r = $urandom_range(0, 7);
		end
		send_edge(p, r, $urandom_range(0, 1));
	endtask

	task automatic test_basic_cycle;
		send_edge(0, 0, DIR_REQUEST);
		send_edge(1, 0, DIR_ASSIGN);
		send_edge(1, 1, DIR_REQUEST);
		send_edge(0, 1, DIR_ASSIGN);
		send_edge(2, 1, DIR_REQUEST);
		drain();
	endtask

	task automatic test_extreme_ids;
		send_edge(31, 31, DIR_REQUEST);
		send_edge(31, 31, DIR_ASSIGN);
		send_edge(30, 31, DIR_REQUEST);
		send_edge(31, 0, DIR_REQUEST);
		send_edge(0, 31, DIR_ASSIGN);
		drain();
	endtask

	task automatic test_random_phases;
		int pct_send[4] = '{0, 86, 0, 37};
		int pct_stall[4] = '{0, 0, 86, 37};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = pct_send[ph];
			stall_pct = pct_stall[ph];
			repeat (45) send_random_edge();
		end
		send_idle_pct = 0;
		stall_pct = 0;
		drain();
	endtask

	task automatic test_long_hold_off;
		hold_cycles = 60000;
		repeat (5) send_random_edge();
		drain();
	endtask

	task automatic test_store_full;
		stall_pct = 37;
		send_edge(0, 0, DIR_REQUEST);
		send_edge(0, 0, DIR_ASSIGN);
		for (int i = 0; i < MAX_PROCS_DEF && stored_edges < MAX_EDGES_DEF; i++)
			send_edge(i, 0, DIR_REQUEST);
		while (stored_edges < MAX_EDGES_DEF)
			send_random_edge();
		repeat (4) send_random_edge();
		stall_pct = 0;
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		result_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = expected_results.pop_front();
				if (result_item.deadlocked !== want.deadlocked)
					report_mismatch($sformatf("deadlocked %b want %b",
						result_item.deadlocked, want.deadlocked));
				if (result_item.stuck_process !== want.stuck_process)
					report_mismatch($sformatf("stuck_process %0d want %0d",
						result_item.stuck_process, want.stuck_process));
				if (result_item.edge_number !== want.edge_number)
					report_mismatch($sformatf("edge_number %0d want %0d",
						result_item.edge_number, want.edge_number));
				if (result_item.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run %b want %b",
						result_item.last_of_run, want.last_of_run));
				if (result_item.edge_dropped !== want.edge_dropped)
					report_mismatch($sformatf("edge_dropped %b want %b",
						result_item.edge_dropped, want.edge_dropped));
			end
		end
	end

	always @(posedge clk) begin
		if ((edge_valid && !edge_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		for (int n = 0; n < NODES; n++)
			out_degree[n] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_basic_cycle();
		test_extreme_ids();
		test_random_phases();
		test_long_hold_off();
		test_store_full();
		if (expected_results.size() != 0)
			report_mismatch("expected results left over");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/iddt_pkg.sv
hw/rtl/iddt_ram.sv
hw/rtl/incremental_deadlock_detect_top.sv
dv/tb_top.sv
